// ===== rtl/napt_pkg.sv =====
// Package for the NAPT port translation engine.
// Table sizes, action codes, opcodes and the cell interface structs.
// Used by every module in rtl/.
package napt_pkg;

  localparam int MapEntries     = 16;
  localparam int SessionEntries = 32;
  localparam int BlockEntries   = 8;

  localparam int MapIdxW   = $clog2(MapEntries);
  localparam int MapCntW   = $clog2(MapEntries + 1);
  localparam int SessIdxW  = $clog2(SessionEntries);
  localparam int SessCntW  = $clog2(SessionEntries + 1);
  localparam int BlockIdxW = $clog2(BlockEntries);
  localparam int BlockCntW = $clog2(BlockEntries + 1);

  localparam logic [15:0] InReplyPort  = 16'd4321;
  localparam logic [15:0] OutReplyPort = 16'd1234;
  localparam logic [15:0] PortBaseRst  = 16'd2000;
  localparam logic [15:0] PortStep     = 16'd100;

  typedef enum logic [1:0] {
    OP_OUTBOUND = 2'd0,
    OP_INBOUND  = 2'd1,
    OP_ADD_RANGE = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ACT_FORWARD    = 3'd0,
    ACT_DROP_REPLY = 3'd1,
    ACT_SILENT     = 3'd2,
    ACT_MAP_FULL   = 3'd3,
    ACT_DONE       = 3'd4,
    ACT_RANGE_FULL = 3'd5
  } action_t;

  typedef enum logic [0:0] {
    CFG_PUBLIC_ADDRESS = 1'b0,
    CFG_PORT_BASE      = 1'b1
  } cfg_idx_t;

  // search key broadcast into the row of cells
  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] ip2;
    logic [15:0] port2;
  } key_t;

  // write command to one cell
  typedef struct packed {
    logic        wr;
    logic [31:0] a_ip;
    logic [15:0] a_port;
    logic [31:0] b_ip;
    logic [15:0] b_port;
  } cell_wr_t;

endpackage

// ===== rtl/napt_map_cell.sv =====
// One mapping table cell: local and public pair plus valid bit.
// Compares both sides against a key; chains a first-hit index down the row.
// Depends on napt_pkg.
module napt_map_cell
  import napt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clr,
  input  cell_wr_t             wr,
  input  key_t                 key,
  input  logic [MapIdxW-1:0]   my_idx,
  input  logic                 hit_loc_in,
  input  logic [MapIdxW-1:0]   idx_loc_in,
  input  logic                 hit_pub_in,
  input  logic [MapIdxW-1:0]   idx_pub_in,
  output logic                 hit_loc_out,
  output logic [MapIdxW-1:0]   idx_loc_out,
  output logic                 hit_pub_out,
  output logic [MapIdxW-1:0]   idx_pub_out,
  output logic [31:0]          loc_ip,
  output logic [15:0]          loc_port,
  output logic [31:0]          pub_ip,
  output logic [15:0]          pub_port
);

  logic valid_r;
  logic [31:0] loc_ip_r, pub_ip_r;
  logic [15:0] loc_port_r, pub_port_r;
  logic m_loc, m_pub;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (clr) begin
      valid_r <= 1'b0;
    end else if (wr.wr) begin
      valid_r <= 1'b1;
    end
    if (wr.wr) begin
      loc_ip_r   <= wr.a_ip;
      loc_port_r <= wr.a_port;
      pub_ip_r   <= wr.b_ip;
      pub_port_r <= wr.b_port;
    end
  end

  assign m_loc = valid_r && loc_ip_r == key.ip && loc_port_r == key.port;
  assign m_pub = valid_r && pub_ip_r == key.ip2 && pub_port_r == key.port2;

  // lower index sits upstream: keep an earlier hit
  assign hit_loc_out = hit_loc_in | m_loc;
  assign idx_loc_out = hit_loc_in ? idx_loc_in : my_idx;
  assign hit_pub_out = hit_pub_in | m_pub;
  assign idx_pub_out = hit_pub_in ? idx_pub_in : my_idx;
  assign loc_ip   = loc_ip_r;
  assign loc_port = loc_port_r;
  assign pub_ip   = pub_ip_r;
  assign pub_port = pub_port_r;

endmodule

// ===== rtl/napt_sess_cell.sv =====
// One session table cell: public pair and remote pair plus valid bit.
// ORs its match into the hit chain. Depends on napt_pkg.
module napt_sess_cell
  import napt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     clr,
  input  cell_wr_t wr,
  input  key_t     key,
  input  logic     hit_in,
  output logic     hit_out
);

  logic valid_r;
  logic [31:0] p_ip_r, r_ip_r;
  logic [15:0] p_port_r, r_port_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (clr) begin
      valid_r <= 1'b0;
    end else if (wr.wr) begin
      valid_r <= 1'b1;
    end
    if (wr.wr) begin
      p_ip_r   <= wr.a_ip;
      p_port_r <= wr.a_port;
      r_ip_r   <= wr.b_ip;
      r_port_r <= wr.b_port;
    end
  end

  assign hit_out = hit_in | (valid_r && p_ip_r == key.ip && p_port_r == key.port &&
                             r_ip_r == key.ip2 && r_port_r == key.port2);

endmodule

// ===== rtl/napt_block_cell.sv =====
// One blocked port range cell with valid bit.
// ORs its in-range test into the hit chain. Depends on napt_pkg.
module napt_block_cell
  import napt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        clr,
  input  logic        wr,
  input  logic [15:0] wr_first,
  input  logic [15:0] wr_last,
  input  logic [15:0] port,
  input  logic        hit_in,
  output logic        hit_out
);

  logic valid_r;
  logic [15:0] first_r, last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (clr) begin
      valid_r <= 1'b0;
    end else if (wr) begin
      valid_r <= 1'b1;
    end
    if (wr) begin
      first_r <= wr_first;
      last_r  <= wr_last;
    end
  end

  assign hit_out = hit_in | (valid_r && port >= first_r && port <= last_r);

endmodule

// ===== rtl/nat_port_translation_engine.sv =====
// NAPT port translation engine, top level.
// Row of mapping, session and block-range cells with a small sequencer.
// Depends on napt_pkg, napt_map_cell, napt_sess_cell, napt_block_cell.
//
// Input: the word is taken at an edge with start high and busy low.
// Result: out_valid pulses for one cycle with action and header fields;
// every word gives exactly one result and the receiver cannot stall.
// Config: cfg_valid writes public_address (index 0) or port_base (index 1);
// cfg_ready is always high. Write only while idle.
// Sequence: after the accept edge the lookup state compares all mapping,
// session and block cells in parallel and writes a new mapping or range.
// A word other than a forwarded outbound packet shows its result in the
// next cycle. A forwarded outbound packet passes through the session
// state, which searches and writes the session cells.
// busy is low during the result cycle, so the next word can be taken at
// the edge that ends it. alloc_counter/3 and mod 3 are kept as counters.
// Reset: clears valid bits, counters, state, public_address; port_base 2000.
module nat_port_translation_engine
  import napt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_source_ip,
  input  logic [15:0] in_source_port,
  input  logic [31:0] in_dest_ip,
  input  logic [15:0] in_dest_port,
  input  logic [15:0] in_range_first,
  input  logic [15:0] in_range_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  output logic [2:0]  out_action,
  output logic [31:0] out_source_ip,
  output logic [15:0] out_source_port,
  output logic [31:0] out_dest_ip,
  output logic [15:0] out_dest_port,
  output logic        out_mapping_created,
  output logic        out_session_lost
);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_SESS} state_t;

  state_t state_r;
  logic [1:0]  op_r;
  logic [31:0] sip_r, dip_r;
  logic [15:0] sport_r, dport_r, rfirst_r, rlast_r;
  logic [31:0] public_address_r;
  logic [15:0] port_base_r;
  logic [MapCntW-1:0]   map_count_r;
  logic [SessCntW-1:0]  sess_count_r;
  logic [BlockCntW-1:0] block_count_r;
  logic [15:0] alloc_r;
  logic [15:0] alloc_div_r;
  logic [1:0]  alloc_mod_r;
  logic [31:0] pip_r;
  logic [15:0] pport_r;
  logic        created_r;

  logic [2:0]  act_r;
  logic [31:0] osip_r, odip_r;
  logic [15:0] osport_r, odport_r;
  logic        ovalid_r, lost_r, mc_r;

  logic clr;
  key_t map_key, sess_key;

  logic [MapEntries:0]  hl, hp;
  logic [MapIdxW-1:0]   il [MapEntries+1];
  logic [MapIdxW-1:0]   ip [MapEntries+1];
  logic [31:0] c_loc_ip [MapEntries];
  logic [15:0] c_loc_port [MapEntries];
  logic [31:0] c_pub_ip [MapEntries];
  logic [15:0] c_pub_port [MapEntries];
  cell_wr_t    map_wr [MapEntries];
  logic [SessionEntries:0] hs;
  cell_wr_t    sess_wr [SessionEntries];
  logic [BlockEntries:0] hb;

  logic map_wr_en, sess_wr_en;
  logic [31:0] new_pip;
  logic [15:0] new_pport;
  logic [15:0] step_mul;

  assign clr = state_r == S_LOOK && op_r == OP_CLEAR;
  assign map_key  = '{ip: sip_r, port: sport_r, ip2: dip_r, port2: dport_r};
  assign sess_key = (op_r == OP_INBOUND) ?
                    key_t'{ip: dip_r, port: dport_r, ip2: sip_r, port2: sport_r} :
                    key_t'{ip: pip_r, port: pport_r, ip2: dip_r, port2: dport_r};

  assign hl[0] = 1'b0;
  assign hp[0] = 1'b0;
  assign il[0] = '0;
  assign ip[0] = '0;
  assign hs[0] = 1'b0;
  assign hb[0] = 1'b0;

  always_comb begin
    case (alloc_mod_r)
      2'd0:    step_mul = 16'd0;
      2'd1:    step_mul = PortStep;
      default: step_mul = 16'(PortStep + PortStep);
    endcase
  end

  assign new_pip   = public_address_r + {16'd0, alloc_div_r} + 32'd1;
  assign new_pport = port_base_r + step_mul;

  // lookup phase decisions
  logic blocked, loc_hit, pub_hit, map_full;
  logic [MapIdxW-1:0] loc_k, pub_k;
  assign blocked  = hb[BlockEntries];
  assign loc_hit  = hl[MapEntries];
  assign pub_hit  = hp[MapEntries];
  assign loc_k    = il[MapEntries];
  assign pub_k    = ip[MapEntries];
  assign map_full = map_count_r == MapCntW'(MapEntries);

  assign map_wr_en  = state_r == S_LOOK && op_r == OP_OUTBOUND && !blocked &&
                      !loc_hit && !map_full;
  assign sess_wr_en = state_r == S_SESS && !hs[SessionEntries] &&
                      sess_count_r != SessCntW'(SessionEntries);

  genvar g;
  generate
    for (g = 0; g < MapEntries; g++) begin : g_map
      assign map_wr[g] = '{wr: map_wr_en && map_count_r == MapCntW'(g),
                           a_ip: sip_r, a_port: sport_r,
                           b_ip: new_pip, b_port: new_pport};
      napt_map_cell u_cell (
        .clk, .rst_n, .clr, .wr(map_wr[g]), .key(map_key),
        .my_idx(MapIdxW'(g)),
        .hit_loc_in(hl[g]), .idx_loc_in(il[g]),
        .hit_pub_in(hp[g]), .idx_pub_in(ip[g]),
        .hit_loc_out(hl[g+1]), .idx_loc_out(il[g+1]),
        .hit_pub_out(hp[g+1]), .idx_pub_out(ip[g+1]),
        .loc_ip(c_loc_ip[g]), .loc_port(c_loc_port[g]),
        .pub_ip(c_pub_ip[g]), .pub_port(c_pub_port[g])
      );
    end
    for (g = 0; g < SessionEntries; g++) begin : g_sess
      assign sess_wr[g] = '{wr: sess_wr_en && sess_count_r == SessCntW'(g),
                            a_ip: pip_r, a_port: pport_r,
                            b_ip: dip_r, b_port: dport_r};
      napt_sess_cell u_cell (
        .clk, .rst_n, .clr, .wr(sess_wr[g]), .key(sess_key),
        .hit_in(hs[g]), .hit_out(hs[g+1])
      );
    end
    for (g = 0; g < BlockEntries; g++) begin : g_blk
      napt_block_cell u_cell (
        .clk, .rst_n, .clr,
        .wr(state_r == S_LOOK && op_r == OP_ADD_RANGE &&
            block_count_r == BlockCntW'(g)),
        .wr_first(rfirst_r), .wr_last(rlast_r), .port(sport_r),
        .hit_in(hb[g]), .hit_out(hb[g+1])
      );
    end
  endgenerate

  assign cfg_ready = 1'b1;
  assign busy = state_r != S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      ovalid_r         <= 1'b0;
      public_address_r <= '0;
      port_base_r      <= PortBaseRst;
      map_count_r      <= '0;
      sess_count_r     <= '0;
      block_count_r    <= '0;
      alloc_r          <= '0;
      alloc_div_r      <= '0;
      alloc_mod_r      <= '0;
    end else begin
      ovalid_r <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_PUBLIC_ADDRESS: public_address_r <= cfg_data;
          CFG_PORT_BASE:      port_base_r      <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r     <= in_op;
            sip_r    <= in_source_ip;
            sport_r  <= in_source_port;
            dip_r    <= in_dest_ip;
            dport_r  <= in_dest_port;
            rfirst_r <= in_range_first;
            rlast_r  <= in_range_last;
            state_r  <= S_LOOK;
          end
        end
        S_LOOK: begin
          act_r    <= ACT_DONE;
          osip_r   <= '0;
          osport_r <= '0;
          odip_r   <= '0;
          odport_r <= '0;
          mc_r     <= 1'b0;
          lost_r   <= 1'b0;
          state_r  <= S_IDLE;
          ovalid_r <= 1'b1;
          case (op_r)
            OP_OUTBOUND: begin
              if (blocked) begin
                act_r    <= ACT_DROP_REPLY;
                osip_r   <= public_address_r;
                osport_r <= OutReplyPort;
                odip_r   <= sip_r;
                odport_r <= sport_r;
              end else if (loc_hit) begin
                pip_r     <= c_pub_ip[loc_k];
                pport_r   <= c_pub_port[loc_k];
                created_r <= 1'b0;
                ovalid_r  <= 1'b0;
                state_r   <= S_SESS;
              end else if (map_full) begin
                act_r <= ACT_MAP_FULL;
              end else begin
                pip_r       <= new_pip;
                pport_r     <= new_pport;
                created_r   <= 1'b1;
                map_count_r <= map_count_r + 1'b1;
                alloc_r     <= alloc_r + 16'd1;
                if (alloc_mod_r == 2'd2) begin
                  alloc_mod_r <= 2'd0;
                  alloc_div_r <= alloc_div_r + 16'd1;
                end else begin
                  alloc_mod_r <= alloc_mod_r + 2'd1;
                end
                if (alloc_r == 16'hFFFF) begin
                  alloc_mod_r <= 2'd0;
                  alloc_div_r <= '0;
                end
                ovalid_r <= 1'b0;
                state_r  <= S_SESS;
              end
            end
            OP_INBOUND: begin
              if (!pub_hit) begin
                act_r <= ACT_SILENT;
              end else if (!hs[SessionEntries]) begin
                act_r    <= ACT_DROP_REPLY;
                osip_r   <= public_address_r;
                osport_r <= InReplyPort;
                odip_r   <= sip_r;
                odport_r <= sport_r;
              end else begin
                act_r    <= ACT_FORWARD;
                osip_r   <= sip_r;
                osport_r <= sport_r;
                odip_r   <= c_loc_ip[pub_k];
                odport_r <= c_loc_port[pub_k];
              end
            end
            OP_ADD_RANGE: begin
              if (block_count_r == BlockCntW'(BlockEntries)) begin
                act_r <= ACT_RANGE_FULL;
              end else begin
                block_count_r <= block_count_r + 1'b1;
              end
            end
            default: begin
              map_count_r   <= '0;
              sess_count_r  <= '0;
              block_count_r <= '0;
            end
          endcase
        end
        S_SESS: begin
          if (sess_wr_en) sess_count_r <= sess_count_r + 1'b1;
          act_r    <= ACT_FORWARD;
          osip_r   <= pip_r;
          osport_r <= pport_r;
          odip_r   <= dip_r;
          odport_r <= dport_r;
          mc_r     <= created_r;
          lost_r   <= !hs[SessionEntries] &&
                      sess_count_r == SessCntW'(SessionEntries);
          ovalid_r <= 1'b1;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = ovalid_r;
  assign out_action          = act_r;
  assign out_source_ip       = osip_r;
  assign out_source_port     = osport_r;
  assign out_dest_ip         = odip_r;
  assign out_dest_port       = odport_r;
  assign out_mapping_created = mc_r;
  assign out_session_lost    = lost_r;

`ifndef ASSERT_OFF
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) != S_IDLE) else $error("result without work");
  a_map_bound: assert property (@(posedge clk) disable iff (!rst_n)
    map_count_r <= MapCntW'(MapEntries)) else $error("map count overflow");
  a_sess_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sess_count_r <= SessCntW'(SessionEntries)) else $error("session count overflow");
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy after result");
`endif

endmodule
